### rtl/srecord_stream_parser_top_defines.svh
// Assertion macros shared by the S-record parser checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SRECORD_STREAM_PARSER_TOP_DEFINES_SVH
`define SRECORD_STREAM_PARSER_TOP_DEFINES_SVH

// property checked outside reset
`define SRP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property that must also hold while reset is asserted
`define SRP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/srp_pkg.sv
// Shared types, constants and helpers for the S-record stream parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package srp_pkg;

   localparam int ADDR_BITS = 32;
   localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_BITS) - 64'd1);
   localparam logic [31:0] ADDR_LIMIT_RESET = 32'h0000_8C56;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_THREE = 8'h33;
   localparam logic [7:0] CHAR_SEVEN = 8'h37;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UC_A  = 8'h41;
   localparam logic [7:0] CHAR_UC_F  = 8'h46;
   localparam logic [7:0] CHAR_LC_A  = 8'h61;
   localparam logic [7:0] CHAR_LC_F  = 8'h66;
   localparam logic [7:0] CSUM_GOOD  = 8'hFF;

   typedef enum logic [2:0] {
      PH_WAIT,
      PH_TYPE,
      PH_SKIP,
      PH_COUNT,
      PH_ADDR,
      PH_DATA,
      PH_CSUM,
      PH_HALT
   } phase_type;

   typedef enum logic [2:0] {
      KIND_DATA     = 3'd0,
      KIND_OK       = 3'd1,
      KIND_CSUM_ERR = 3'd2,
      KIND_ADDR_ERR = 3'd3,
      KIND_LEN_ERR  = 3'd4,
      KIND_LOADED   = 3'd5,
      KIND_EMPTY    = 3'd6
   } kind_type;

   // one classified character as it travels from front to back
   typedef struct packed {
      logic       is_s;
      logic       is_eol;
      logic       is_rec_type;   // '1'..'3'
      logic       is_end_type;   // '7'..'9'
      logic [1:0] type_code;     // low bits of the type digit
      logic [3:0] hex;           // digit value, 0 when not hex
   } char_class_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] address;
      logic [7:0]  data;
   } result_type;

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         v = 4'(c - CHAR_ZERO);
      end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
         v = 4'(c - CHAR_UC_A + 8'd10);
      end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
         v = 4'(c - CHAR_LC_A + 8'd10);
      end
      return v;
   endfunction

endpackage

`default_nettype wire

### rtl/srecord_stream_parser_top.sv
// S-record stream parser: takes one ASCII character per transaction and
// returns data bytes with addresses, record verdicts and end-of-load status.
// One character is taken each clock while req_stall is low; each one is
// classified at the input, held in a four-entry queue and consumed by the
// parser step, which registers any result. The queue and the
// output register absorb rsp_stall; req_stall rises only when the queue is
// full. After an error or an S7/S8/S9 terminator, input is consumed and
// ignored until reset.
// Depends on srp_pkg, srp_front, srp_queue, srp_back.
`default_nettype none

module srecord_stream_parser_top
   import srp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_wr_en,
   input  wire logic [31:0]    csr_wr_data,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire logic [7:0]     req_char_in,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output logic [2:0]          rsp_result_kind,
   output logic [31:0]         rsp_byte_address,
   output logic [7:0]          rsp_data_byte
);

   char_class_type  char_class;
   char_class_type  q_head;
   logic            q_full;
   logic            q_not_empty;
   logic            q_pop;
   result_type      result;

   srp_front u_front (
      .char_in    (req_char_in),
      .char_class (char_class)
   );

   srp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && !q_full),
      .push_data (char_class),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   srp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (q_not_empty),
      .item        (q_head),
      .item_pop    (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_result  (result)
   );

   assign req_stall        = q_full;
   assign rsp_result_kind  = result.kind;
   assign rsp_byte_address = result.address;
   assign rsp_data_byte    = result.data;

endmodule

`default_nettype wire

### rtl/srp_front.sv
// Front end: classifies each received character for the parser.
// Depends on srp_pkg.
`default_nettype none

module srp_front
   import srp_pkg::*;
(
   input  wire logic [7:0]     char_in,
   output char_class_type      char_class
);

   always_comb begin
      char_class.is_s        = (char_in == CHAR_S);
      char_class.is_eol      = (char_in == CHAR_CR) || (char_in == CHAR_LF);
      char_class.is_rec_type = (char_in >= CHAR_ONE) && (char_in <= CHAR_THREE);
      char_class.is_end_type = (char_in >= CHAR_SEVEN) && (char_in <= CHAR_NINE);
      char_class.type_code   = char_in[1:0];
      char_class.hex         = hex_value(char_in);
   end

endmodule

`default_nettype wire

### rtl/srp_queue.sv
// Small FIFO of classified characters between front and back.
// Depends on srp_pkg.
`default_nettype none

module srp_queue
   import srp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire char_class_type push_data,
   output logic                full,
   input  wire logic           pop,
   output logic                not_empty,
   output char_class_type      head
);

   char_class_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]    count_ff, count_in;

   assign full      = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/srp_back.sv
// Back end: record parser state machine, address limit register and
// output register. Depends on srp_pkg.
`default_nettype none

module srp_back
   import srp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_wr_en,
   input  wire logic [31:0]    csr_wr_data,
   input  wire logic           item_valid,
   input  wire char_class_type item,
   output logic                item_pop,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output result_type          rsp_result
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  addr_digits_ff, addr_digits_in;
   logic [3:0]  digit_cnt_ff, digit_cnt_in;
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [31:0] rec_addr_ff, rec_addr_in;
   logic [31:0] next_addr_ff, next_addr_in;
   logic [7:0]  remaining_ff, remaining_in;
   logic [7:0]  sum_ff, sum_in;
   logic [3:0]  high_nib_ff, high_nib_in;
   logic        any_data_ff, any_data_in;
   logic [31:0] limit_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_result_ff;

   logic        emit;
   result_type  res;
   logic [7:0]  byte_val;
   logic        byte_done;
   logic [3:0]  cnt_inc;
   logic [31:0] addr_shift;
   logic [31:0] addr_masked;
   logic [7:0]  overhead;
   logic [7:0]  csum_total;

   // a result slot is free when empty or being drained this cycle
   assign item_pop = item_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      phase_in       = phase_ff;
      addr_digits_in = addr_digits_ff;
      digit_cnt_in   = digit_cnt_ff;
      byte_count_in  = byte_count_ff;
      rec_addr_in    = rec_addr_ff;
      next_addr_in   = next_addr_ff;
      remaining_in   = remaining_ff;
      sum_in         = sum_ff;
      high_nib_in    = high_nib_ff;
      any_data_in    = any_data_ff;
      emit           = 1'b0;
      res            = '{kind: KIND_DATA, address: '0, data: '0};

      byte_val    = {high_nib_ff, item.hex};
      byte_done   = digit_cnt_ff[0];
      cnt_inc     = digit_cnt_ff + 4'd1;
      addr_shift  = {rec_addr_ff[23:0], byte_val};
      addr_masked = addr_shift & ADDR_MASK;
      overhead    = {5'd0, addr_digits_ff[3:1]} + 8'd1;
      csum_total  = sum_ff + byte_val;

      if (item_pop) begin
         // first digit of every byte pair lands in the high nibble
         if (!byte_done) begin
            high_nib_in = item.hex;
         end
         unique case (phase_ff)
            PH_WAIT: begin
               if (item.is_s) begin
                  phase_in = PH_TYPE;
               end
            end
            PH_TYPE: begin
               if (item.is_rec_type) begin
                  addr_digits_in = {({1'b0, item.type_code} + 3'd1), 1'b0};
                  digit_cnt_in   = '0;
                  rec_addr_in    = '0;
                  sum_in         = '0;
                  phase_in       = PH_COUNT;
               end else if (item.is_end_type) begin
                  phase_in = PH_HALT;
                  emit     = 1'b1;
                  res.kind = any_data_ff ? KIND_LOADED : KIND_EMPTY;
               end else begin
                  phase_in = item.is_eol ? PH_WAIT : PH_SKIP;
               end
            end
            PH_SKIP: begin
               if (item.is_eol) begin
                  phase_in = PH_WAIT;
               end
            end
            PH_COUNT: begin
               if (byte_done) begin
                  byte_count_in = byte_val;
                  sum_in        = byte_val;
                  digit_cnt_in  = '0;
                  phase_in      = PH_ADDR;
               end else begin
                  digit_cnt_in = cnt_inc;
               end
            end
            PH_ADDR: begin
               digit_cnt_in = cnt_inc;
               if (byte_done) begin
                  rec_addr_in = addr_shift;
                  sum_in      = sum_ff + byte_val;
                  // address digit counts are even, so the last digit closes a byte
                  if (cnt_inc >= addr_digits_ff) begin
                     rec_addr_in  = addr_masked;
                     next_addr_in = addr_masked;
                     digit_cnt_in = '0;
                     res.address  = addr_masked;
                     if (addr_masked >= limit_ff) begin
                        phase_in = PH_HALT;
                        emit     = 1'b1;
                        res.kind = KIND_ADDR_ERR;
                     end else if (byte_count_ff < overhead) begin
                        phase_in = PH_HALT;
                        emit     = 1'b1;
                        res.kind = KIND_LEN_ERR;
                     end else begin
                        remaining_in = byte_count_ff - overhead;
                        phase_in     = (byte_count_ff == overhead) ? PH_CSUM : PH_DATA;
                     end
                  end
               end
            end
            PH_DATA: begin
               if (byte_done) begin
                  digit_cnt_in = '0;
                  next_addr_in = (next_addr_ff + 32'd1) & ADDR_MASK;
                  sum_in       = sum_ff + byte_val;
                  any_data_in  = 1'b1;
                  remaining_in = remaining_ff - 8'd1;
                  if (remaining_ff == 8'd1) begin
                     phase_in = PH_CSUM;
                  end
                  emit        = 1'b1;
                  res.kind    = KIND_DATA;
                  res.address = next_addr_ff;
                  res.data    = byte_val;
               end else begin
                  digit_cnt_in = cnt_inc;
               end
            end
            PH_CSUM: begin
               if (byte_done) begin
                  digit_cnt_in = '0;
                  emit         = 1'b1;
                  res.address  = rec_addr_ff;
                  if (csum_total == CSUM_GOOD) begin
                     phase_in = PH_WAIT;
                     res.kind = KIND_OK;
                  end else begin
                     phase_in = PH_HALT;
                     res.kind = KIND_CSUM_ERR;
                  end
               end else begin
                  digit_cnt_in = cnt_inc;
               end
            end
            PH_HALT: begin
               phase_in = PH_HALT;
            end
            default: begin
               phase_in = PH_HALT;
            end
         endcase
      end

      rsp_valid_in = (item_pop && emit) || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_WAIT;
         addr_digits_ff <= '0;
         digit_cnt_ff   <= '0;
         byte_count_ff  <= '0;
         rec_addr_ff    <= '0;
         next_addr_ff   <= '0;
         remaining_ff   <= '0;
         sum_ff         <= '0;
         high_nib_ff    <= '0;
         any_data_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         limit_ff       <= ADDR_LIMIT_RESET;
      end else begin
         phase_ff       <= phase_in;
         addr_digits_ff <= addr_digits_in;
         digit_cnt_ff   <= digit_cnt_in;
         byte_count_ff  <= byte_count_in;
         rec_addr_ff    <= rec_addr_in;
         next_addr_ff   <= next_addr_in;
         remaining_ff   <= remaining_in;
         sum_ff         <= sum_in;
         high_nib_ff    <= high_nib_in;
         any_data_ff    <= any_data_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop && emit) begin
         rsp_result_ff <= res;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

endmodule

`default_nettype wire

### rtl/srp_checker.sv
// Port-level checker for the S-record parser, bound to the top level.
// Depends on srp_pkg and srecord_stream_parser_top_defines.svh.
`default_nettype none
`include "srecord_stream_parser_top_defines.svh"

module srp_checker
   import srp_pkg::*;
(
   input wire logic           clock,
   input wire logic           reset,
   input wire logic           rsp_valid,
   input wire logic           rsp_stall,
   input wire logic [2:0]     rsp_result_kind,
   input wire logic [31:0]    rsp_byte_address,
   input wire logic [7:0]     rsp_data_byte
);

   `SRP_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "rsp_valid after reset")

   `SRP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_kind) && $stable(rsp_byte_address) && $stable(rsp_data_byte), "stalled response changed")

   `SRP_ASSERT(a_kind_range, clock, reset, rsp_valid |-> rsp_result_kind <= KIND_EMPTY, "result kind out of range")

   `SRP_ASSERT(a_verdict_no_data, clock, reset, rsp_valid && rsp_result_kind != KIND_DATA |-> rsp_data_byte == 8'd0, "data byte on verdict")

   `SRP_ASSERT(a_end_no_addr, clock, reset, rsp_valid && (rsp_result_kind == KIND_LOADED || rsp_result_kind == KIND_EMPTY) |-> rsp_byte_address == 32'd0, "address on end status")

endmodule

bind srecord_stream_parser_top srp_checker u_checker (.*);

`default_nettype wire

### tb/tb_srecord_stream_parser_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for srecord_stream_parser_top: directed table, then
// random S-record streams, checked against an in-bench parser model.
// Depends on srp_pkg and the srecord_stream_parser_top RTL.

module tb_srecord_stream_parser_top;
   import srp_pkg::*;

   localparam int CLK_PERIOD   = 12;
   localparam int QUIET_CYCLES = 16;
   localparam int HOLD_CYCLES  = 120;
   localparam int HOLD_AFTER   = 150;
   localparam logic [31:0] ADDR_KEEP = 32'((64'd1 << ADDR_BITS) - 64'd1);

   typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_FIXED} row_mode_type;
   typedef enum int {END_CSUM, END_ADDR, END_LEN, END_TERM} ending_kind_type;

   typedef struct packed {
      row_mode_type mode;
      result_type   res;
   } char_tag_type;

   typedef struct packed {
      logic [7:0]   ch;
      row_mode_type mode;
      result_type   res;
   } stim_row_type;

   localparam result_type NO_RES = '{KIND_DATA, 32'h0, 8'h00};

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_char_in;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_result_kind;
   logic [31:0] rsp_byte_address;
   logic [7:0]  rsp_data_byte;

   srecord_stream_parser_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_in      (req_char_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_byte_address (rsp_byte_address),
      .rsp_data_byte    (rsp_data_byte)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // parser model state
   phase_type   st_phase      = PH_WAIT;
   logic [3:0]  st_addr_nibs  = '0;
   logic [3:0]  st_digit_idx  = '0;
   logic [7:0]  st_count      = '0;
   logic [31:0] st_rec_addr   = '0;
   logic [31:0] st_next_addr  = '0;
   logic [7:0]  st_left       = '0;
   logic [7:0]  st_sum        = '0;
   logic [3:0]  st_hi         = '0;
   logic        st_seen_data  = 1'b0;
   logic [31:0] cur_addr_limit = ADDR_LIMIT_RESET;

   result_type      expected_results[$];
   char_tag_type    char_tags[$];
   stim_row_type    directed_rows[29];

   int              fail_count    = 0;
   int              results_seen  = 0;
   int              data_bytes    = 0;
   int              good_records  = 0;
   int              chars_taken   = 0;
   int              chars_sent    = 0;
   int              limit_writes  = 0;
   bit              calm          = 1'b0;
   ending_kind_type ending;

   function automatic bit is_hex_char(input logic [7:0] c);
      return (c >= CHAR_ZERO && c <= CHAR_NINE) || (c >= CHAR_UC_A && c <= CHAR_UC_F) ||
             (c >= CHAR_LC_A && c <= CHAR_LC_F);
   endfunction

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return 4'(c - CHAR_ZERO);
      if (c >= CHAR_UC_A && c <= CHAR_UC_F) return 4'(c - CHAR_UC_A + 8'd10);
      if (c >= CHAR_LC_A && c <= CHAR_LC_F) return 4'(c - CHAR_LC_A + 8'd10);
      return 4'd0;
   endfunction

   // one digit of a hex pair; true once the second digit completes the byte
   function automatic bit pair_done(input logic [3:0] h, output logic [7:0] b);
      b = {st_hi, h};
      if (!st_digit_idx[0]) begin
         st_hi = h;
         st_digit_idx = st_digit_idx + 4'd1;
         return 1'b0;
      end
      st_digit_idx = st_digit_idx + 4'd1;
      return 1'b1;
   endfunction

   function automatic bit parse_char(input logic [7:0] c, output result_type r);
      logic [3:0] h;
      logic [7:0] b;
      logic [7:0] overhead;
      h = nibble_of(c);
      r = NO_RES;
      parse_char = 1'b0;
      case (st_phase)
         PH_WAIT: begin
            if (c == CHAR_S) st_phase = PH_TYPE;
         end
         PH_TYPE: begin
            if (c >= CHAR_ONE && c <= CHAR_THREE) begin
               st_addr_nibs = 4'(2 * (c - CHAR_ZERO + 8'd1));
               st_digit_idx = '0;
               st_rec_addr  = '0;
               st_sum       = '0;
               st_phase     = PH_COUNT;
            end else if (c >= CHAR_SEVEN && c <= CHAR_NINE) begin
               st_phase = PH_HALT;
               r.kind = st_seen_data ? KIND_LOADED : KIND_EMPTY;
               parse_char = 1'b1;
            end else if (c == CHAR_CR || c == CHAR_LF) begin
               st_phase = PH_WAIT;
            end else begin
               st_phase = PH_SKIP;
            end
         end
         PH_SKIP: begin
            if (c == CHAR_CR || c == CHAR_LF) st_phase = PH_WAIT;
         end
         PH_COUNT: begin
            if (pair_done(h, b)) begin
               st_count     = b;
               st_sum       = b;
               st_digit_idx = '0;
               st_phase     = PH_ADDR;
            end
         end
         PH_ADDR: begin
            if (pair_done(h, b)) begin
               st_rec_addr = {st_rec_addr[23:0], b};
               st_sum      = st_sum + b;
            end
            if (st_digit_idx >= st_addr_nibs) begin
               st_rec_addr  = st_rec_addr & ADDR_KEEP;
               st_next_addr = st_rec_addr;
               st_digit_idx = '0;
               overhead     = 8'(st_addr_nibs / 2 + 1);
               r.address    = st_rec_addr;
               if (st_rec_addr >= cur_addr_limit) begin
                  st_phase = PH_HALT;
                  r.kind = KIND_ADDR_ERR;
                  parse_char = 1'b1;
               end else if (st_count < overhead) begin
                  st_phase = PH_HALT;
                  r.kind = KIND_LEN_ERR;
                  parse_char = 1'b1;
               end else begin
                  st_left  = st_count - overhead;
                  st_phase = (st_left != 0) ? PH_DATA : PH_CSUM;
                  r.address = '0;
               end
            end
         end
         PH_DATA: begin
            if (pair_done(h, b)) begin
               st_digit_idx = '0;
               r.kind       = KIND_DATA;
               r.address    = st_next_addr;
               r.data       = b;
               st_next_addr = (st_next_addr + 32'd1) & ADDR_KEEP;
               st_sum       = st_sum + b;
               st_seen_data = 1'b1;
               st_left      = st_left - 8'd1;
               if (st_left == 0) st_phase = PH_CSUM;
               parse_char = 1'b1;
            end
         end
         PH_CSUM: begin
            if (pair_done(h, b)) begin
               st_digit_idx = '0;
               r.address    = st_rec_addr;
               parse_char   = 1'b1;
               if (8'(st_sum + b) == CSUM_GOOD) begin
                  st_phase = PH_WAIT;
                  r.kind = KIND_OK;
               end else begin
                  st_phase = PH_HALT;
                  r.kind = KIND_CSUM_ERR;
               end
            end
         end
         default: ;
      endcase
   endfunction

   // scoreboard: results are popped before new predictions are queued
   always @(posedge clock) begin : scoreboard
      result_type   want;
      result_type   pred;
      char_tag_type tg;
      bit           made;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_result_kind == KIND_DATA) data_bytes++;
            if (rsp_result_kind == KIND_OK) good_records++;
            if (expected_results.size() == 0) begin
               $error("unexpected result: kind %0d address %h data %h",
                      rsp_result_kind, rsp_byte_address, rsp_data_byte);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_result_kind !== want.kind) begin
                  $error("result_kind: expected %0d, got %0d", want.kind, rsp_result_kind);
                  fail_count++;
               end
               if (rsp_byte_address !== want.address) begin
                  $error("byte_address: expected %h, got %h", want.address, rsp_byte_address);
                  fail_count++;
               end
               if (rsp_data_byte !== want.data) begin
                  $error("data_byte: expected %h, got %h", want.data, rsp_data_byte);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            chars_taken++;
            tg = (char_tags.size() != 0) ? char_tags.pop_front()
                                         : char_tag_type'{ROW_PREDICT, NO_RES};
            made = parse_char(req_char_in, pred);
            case (tg.mode)
               ROW_FIXED:   expected_results.push_back(tg.res);
               ROW_PREDICT: if (made) expected_results.push_back(pred);
               default: ;
            endcase
         end
      end
   end

   // receiver: random stalls, one long hold-off once traffic is flowing
   initial begin : result_sink
      int  hold_left;
      bit  held;
      hold_left = 0;
      held = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && results_seen >= HOLD_AFTER) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 35);
         end
      end
   end

   initial begin : watchdog
      #(CLK_PERIOD * 200000);
      $display("TB_ERROR");
      $finish;
   end

   // one transaction on the character channel; returns at its accepting edge
   task automatic send_char(input logic [7:0] c, input row_mode_type mode = ROW_PREDICT,
                            input result_type fixed = NO_RES);
      if (!calm) begin
         while ($urandom_range(99) < 35) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      char_tags.push_back('{mode, fixed});
      req_valid   <= 1'b1;
      req_char_in <= c;
      chars_sent++;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [7:0] hex_glyph(input logic [3:0] n);
      logic [7:0] c;
      if (n == 4'd0 && $urandom_range(15) == 0) begin
         // a non-hex character decodes as zero
         do c = 8'($urandom); while (is_hex_char(c));
      end else if (n < 4'd10) begin
         c = CHAR_ZERO + 8'(n);
      end else begin
         c = ($urandom_range(1) ? CHAR_UC_A : CHAR_LC_A) + 8'(n - 4'd10);
      end
      return c;
   endfunction

   task automatic send_hex_byte(input logic [7:0] b);
      send_char(hex_glyph(b[7:4]));
      send_char(hex_glyph(b[3:0]));
   endtask

   function automatic logic [31:0] pick_address(input int nb);
      logic [63:0] top;
      top = 64'd1 << (8 * nb);
      if ({32'd0, cur_addr_limit} < top) top = {32'd0, cur_addr_limit};
      case ($urandom_range(5))
         0: return 32'd0;
         1: return 32'(top - 64'd1);
         default: return $urandom_range(32'(top - 64'd1), 0);
      endcase
   endfunction

   // count_force < 0 gives the natural count
   task automatic send_record(input int nb, input logic [31:0] addr, input int n_data,
                              input int count_force, input bit bad_sum);
      logic [7:0] count;
      logic [7:0] sum;
      logic [7:0] b;
      count = (count_force >= 0) ? 8'(count_force) : 8'(nb + n_data + 1);
      send_char(CHAR_S);
      send_char(8'(CHAR_ZERO + 8'(nb - 1)));
      send_hex_byte(count);
      sum = count;
      for (int i = nb - 1; i >= 0; i--) begin
         b = addr[8 * i +: 8];
         send_hex_byte(b);
         sum = sum + b;
      end
      repeat (n_data) begin
         b = 8'($urandom);
         send_hex_byte(b);
         sum = sum + b;
      end
      b = ~sum;
      if (bad_sum) b = b ^ 8'($urandom_range(255, 1));
      send_hex_byte(b);
   endtask

   task automatic send_random_record();
      int nb;
      int n;
      nb = $urandom_range(4, 2);
      n = ($urandom_range(39) == 0) ? $urandom_range(254 - nb, 0) : $urandom_range(8, 0);
      send_record(nb, pick_address(nb), n, -1, 1'b0);
      case ($urandom_range(3))
         1: send_char(CHAR_CR);
         2: send_char(CHAR_LF);
         3: begin
            send_char(CHAR_CR);
            send_char(CHAR_LF);
         end
         default: ;
      endcase
   endtask

   // junk, S0 and unknown-type lines, bare line ends; never starts a record
   task automatic send_noise();
      logic [7:0] c;
      case ($urandom_range(2))
         0: begin
            repeat ($urandom_range(4, 1)) begin
               do c = 8'($urandom); while (c == CHAR_S);
               send_char(c);
            end
         end
         1: begin
            send_char(CHAR_S);
            if ($urandom_range(1)) begin
               c = CHAR_ZERO;
            end else begin
               do c = 8'($urandom);
               while ((c >= CHAR_ONE && c <= CHAR_THREE) || (c >= CHAR_SEVEN && c <= CHAR_NINE)
                      || c == CHAR_CR || c == CHAR_LF);
            end
            send_char(c);
            repeat ($urandom_range(10)) begin
               do c = 8'($urandom); while (c == CHAR_CR || c == CHAR_LF);
               send_char(c);
            end
            send_char($urandom_range(1) ? CHAR_CR : CHAR_LF);
         end
         default: begin
            send_char(CHAR_S);
            send_char($urandom_range(1) ? CHAR_CR : CHAR_LF);
         end
      endcase
   endtask

   task automatic run_random(input int budget);
      int target;
      target = chars_sent + budget;
      while (chars_sent < target) begin
         if ($urandom_range(3) != 0) send_random_record();
         else send_noise();
      end
   endtask

   // sender pauses until every result is back and the queue has drained
   task automatic settle_parser();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0 || char_tags.size() != 0);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic set_address_limit(input logic [31:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_addr_limit = v;
      limit_writes++;
   endtask

   initial begin : stimulus
      int nb;
      logic [31:0] lim;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_valid   = 1'b0;
      req_char_in = '0;

      directed_rows = '{
         '{8'h00,     ROW_NONE,    NO_RES},
         '{8'hFF,     ROW_NONE,    NO_RES},
         '{CHAR_S,    ROW_NONE,    NO_RES},
         '{CHAR_CR,   ROW_NONE,    NO_RES},   // line end as the type
         '{CHAR_S,    ROW_NONE,    NO_RES},
         '{CHAR_ZERO, ROW_NONE,    NO_RES},   // S0 header is skipped
         '{CHAR_LF,   ROW_NONE,    NO_RES},
         // S1 04 0000 ab 50: one byte at address 0
         '{CHAR_S,    ROW_PREDICT, NO_RES},
         '{"1",       ROW_PREDICT, NO_RES},
         '{"0",       ROW_PREDICT, NO_RES},
         '{"4",       ROW_PREDICT, NO_RES},
         '{"0",       ROW_PREDICT, NO_RES},
         '{"0",       ROW_PREDICT, NO_RES},
         '{"0",       ROW_PREDICT, NO_RES},
         '{"0",       ROW_PREDICT, NO_RES},
         '{"a",       ROW_PREDICT, NO_RES},
         '{"b",       ROW_FIXED,   '{KIND_DATA, 32'h0000_0000, 8'hAB}},
         '{"5",       ROW_PREDICT, NO_RES},
         '{"0",       ROW_FIXED,   '{KIND_OK, 32'h0000_0000, 8'h00}},
         // S1 03 01g0 FB: no data, 'g' decodes as zero
         '{CHAR_S,    ROW_PREDICT, NO_RES},
         '{"1",       ROW_PREDICT, NO_RES},
         '{"0",       ROW_PREDICT, NO_RES},
         '{"3",       ROW_PREDICT, NO_RES},
         '{"0",       ROW_PREDICT, NO_RES},
         '{"1",       ROW_PREDICT, NO_RES},
         '{"g",       ROW_PREDICT, NO_RES},
         '{"0",       ROW_PREDICT, NO_RES},
         '{"F",       ROW_PREDICT, NO_RES},
         '{"B",       ROW_FIXED,   '{KIND_OK, 32'h0000_0100, 8'h00}}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_char(directed_rows[i].ch, directed_rows[i].mode, directed_rows[i].res);
      run_random(200);

      // limit 0 rejects any record, so only noise goes in here
      settle_parser();
      set_address_limit(32'h0000_0000);
      repeat (8) send_noise();

      settle_parser();
      set_address_limit(32'hFFFF_FFFF);
      calm = 1'b1;
      run_random(120);
      calm = 1'b0;
      run_random(120);

      settle_parser();
      set_address_limit($urandom_range(32'hFFFF_FFFE, 1));
      run_random(200);

      settle_parser();
      set_address_limit($urandom_range(32'h0000_03FF, 1));
      run_random(200);

      // every ending halts the parser for good, so only one per run
      settle_parser();
      ending = ending_kind_type'($urandom_range(3));
      nb = $urandom_range(4, 2);
      case (ending)
         END_CSUM: send_record(nb, pick_address(nb), $urandom_range(4), -1, 1'b1);
         END_ADDR: begin
            lim = $urandom_range(1) ? 32'h0 : $urandom_range(32'h0000_FFFF, 1);
            set_address_limit(lim);
            send_record(nb, $urandom_range(32'((64'd1 << (8 * nb)) - 64'd1), lim),
                        $urandom_range(3), -1, 1'b0);
         end
         END_LEN: send_record(nb, pick_address(nb), 0, $urandom_range(nb, 0), 1'b0);
         default: begin
            send_char(CHAR_S);
            send_char(8'(CHAR_SEVEN + 8'($urandom_range(2))));
         end
      endcase
      // halted: everything after this is swallowed
      repeat (12) send_char(8'($urandom));

      settle_parser();
      if (expected_results.size() != 0) begin
         $error("%0d expected results never arrived", expected_results.size());
         fail_count++;
      end
      $display("Covered %0d characters, %0d data bytes, %0d good records, %0d limit writes",
               chars_taken, data_bytes, good_records, limit_writes);
      $display("Stream ended by %s", ending.name());
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
